// ===== hw/rtl/csac_pkg.sv =====
// Package: codes, constants and field widths for the clock, setting and alarm controller.
package csac_pkg;

  // Clock tick rate and derived counter width
  localparam int unsigned TicksPerSecond = 100;
  localparam int unsigned TickW          = $clog2(TicksPerSecond + 1);

  // Event kinds carried on the input tuser
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_KEY   = 2'd1;
  localparam logic [1:0] ACT_TEMP  = 2'd2;
  localparam logic [1:0] ACT_EMERG = 2'd3;

  // Display modes
  localparam logic [1:0] MODE_TEMP  = 2'd0;
  localparam logic [1:0] MODE_CLOCK = 2'd1;
  localparam logic [1:0] MODE_SET   = 2'd2;

  // Setting items
  localparam logic [1:0] ITEM_HOUR   = 2'd0;
  localparam logic [1:0] ITEM_MINUTE = 2'd1;
  localparam logic [1:0] ITEM_THRESH = 2'd2;

  // Key codes
  localparam logic [2:0] KEY_NONE = 3'd0;
  localparam logic [2:0] KEY_1    = 3'd1;
  localparam logic [2:0] KEY_2    = 3'd2;
  localparam logic [2:0] KEY_3    = 3'd3;
  localparam logic [2:0] KEY_4    = 3'd4;

  // LED matrix patterns
  localparam logic [1:0] PAT_COLD     = 2'd0;
  localparam logic [1:0] PAT_HOT      = 2'd1;
  localparam logic [1:0] PAT_MODERATE = 2'd2;

  // Chirp requests
  localparam logic [1:0] CHIRP_NONE  = 2'd0;
  localparam logic [1:0] CHIRP_KEY   = 2'd1;
  localparam logic [1:0] CHIRP_EMERG = 2'd3;

  // Limits of the clock and the threshold
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [5:0] THR_MIN    = 6'd10;
  localparam logic [5:0] THR_MAX    = 6'd50;

  // Temperature limits in tenths of a degree
  localparam logic signed [11:0] T_HOT      = 12'sd280;
  localparam logic signed [11:0] T_COLD     = 12'sd200;
  localparam logic signed [11:0] T_DUTY_HI  = 12'sd300;
  localparam logic signed [11:0] T_DUTY_MID = 12'sd250;

  // PWM duty levels
  localparam logic [6:0] DUTY_HI  = 7'd90;
  localparam logic [6:0] DUTY_MID = 7'd60;
  localparam logic [6:0] DUTY_LO  = 7'd30;

  // Reset values
  localparam logic [4:0]         HOUR_RST = 5'd12;
  localparam logic [5:0]         THR_RST  = 6'd30;
  localparam logic signed [11:0] TEMP_RST = 12'sd250;

endpackage

// ===== hw/rtl/clock_setting_alarm_controller.sv =====
// Top level: clock, setting view and temperature alarm controller with stream ports.
//
// One input transaction carries one event (10 ms tick, debounced key sample,
// temperature sample in tenths of a degree, or emergency) and yields exactly one
// result transaction showing the clock, display mode, setting item, threshold and
// alarm after the event, plus a chirp request, an LED PWM duty and a pattern
// choice. The block takes one transaction per clock cycle when the result side
// keeps up: an input register holds the event, the state update and all result
// fields are worked out from it by short logic and land in the result register
// once that register is free or draining, from where the result is offered. The
// input register also absorbs one event while a finished result waits on
// m_axis_tready, so a stall on the result side costs no input cycle until both
// registers are full. Keys act only on a change to a valid sampled code; the
// alarm is refreshed on ticks only.
module clock_setting_alarm_controller
  import csac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] key_code, [14:3] temperature, [15] zero
  input  logic [15:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] hours, [10:5] minutes, [16:11] seconds, [18:17] mode, [20:19] item,
  // [26:21] threshold, [27] alarm_active, [29:28] chirps, [36:30] duty_percent,
  // [38:37] pattern, [39] zero
  output logic [39:0] m_axis_tdata
);

  // Input register
  logic               in_valid_q;
  logic [1:0]         in_action_q;
  logic [2:0]         in_key_q;
  logic signed [11:0] in_temp_q;

  // Controller state
  logic [TickW-1:0]   tick_q, tick_d;
  logic [4:0]         hour_q, hour_d;
  logic [5:0]         minute_q, minute_d;
  logic [5:0]         second_q, second_d;
  logic [1:0]         mode_q, mode_d;
  logic [1:0]         item_q, item_d;
  logic [5:0]         thr_q, thr_d;
  logic signed [11:0] temp_q, temp_d;
  logic               alarm_q, alarm_d;
  logic [2:0]         last_key_q, last_key_d;
  logic [1:0]         pattern_q, pattern_d;

  // Result register
  logic               out_valid_q;
  logic [39:0]        out_data_q, out_data_d;

  logic               advance;
  logic [1:0]         chirps;
  logic [6:0]         duty;
  logic [9:0]         thr_x10;

  // Move the held event into the result register when that register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Threshold in tenths of a degree: 8x + 2x
  assign thr_x10 = {1'b0, thr_q, 3'b000} + {3'b000, thr_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Payload of the input register needs no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action_q <= s_axis_tuser;
      in_key_q    <= s_axis_tdata[2:0];
      in_temp_q   <= $signed(s_axis_tdata[14:3]);
    end
  end

  // Event decode and state update
  always_comb begin
    tick_d     = tick_q;
    hour_d     = hour_q;
    minute_d   = minute_q;
    second_d   = second_q;
    mode_d     = mode_q;
    item_d     = item_q;
    thr_d      = thr_q;
    temp_d     = temp_q;
    alarm_d    = alarm_q;
    last_key_d = last_key_q;
    pattern_d  = pattern_q;
    chirps     = CHIRP_NONE;

    unique case (in_action_q)
      ACT_TICK: begin
        // Advance the clock with carry at the end of each second
        if (tick_q == TickW'(TicksPerSecond - 1)) begin
          tick_d = '0;
          if (second_q >= MINSEC_MAX) begin
            second_d = '0;
            if (minute_q >= MINSEC_MAX) begin
              minute_d = '0;
              hour_d   = (hour_q >= HOUR_MAX) ? 5'd0 : hour_q + 5'd1;
            end else begin
              minute_d = minute_q + 6'd1;
            end
          end else begin
            second_d = second_q + 6'd1;
          end
        end else begin
          tick_d = tick_q + TickW'(1);
        end
        alarm_d = temp_q > $signed({2'b00, thr_x10});
      end
      ACT_KEY: begin
        // Act only on a changed, valid key code
        if (in_key_q <= KEY_4 && in_key_q != last_key_q) begin
          last_key_d = in_key_q;
          if (in_key_q != KEY_NONE) begin
            chirps = CHIRP_KEY;
          end
          unique case (mode_q)
            MODE_TEMP: begin
              if (in_key_q == KEY_1) begin
                mode_d = MODE_CLOCK;
              end else if (in_key_q == KEY_2) begin
                mode_d = MODE_SET;
                item_d = ITEM_THRESH;
              end
            end
            MODE_CLOCK: begin
              if (in_key_q == KEY_1) begin
                mode_d = MODE_TEMP;
              end else if (in_key_q == KEY_2) begin
                mode_d = MODE_SET;
                item_d = ITEM_HOUR;
              end
            end
            MODE_SET: begin
              if (in_key_q == KEY_4) begin
                mode_d = MODE_TEMP;
              end else if (in_key_q == KEY_1) begin
                item_d = (item_q >= ITEM_THRESH) ? ITEM_HOUR : item_q + 2'd1;
              end else if (in_key_q == KEY_2) begin
                // Step the chosen item up with wrap
                if (item_q == ITEM_HOUR) begin
                  hour_d = (hour_q >= HOUR_MAX) ? 5'd0 : hour_q + 5'd1;
                end else if (item_q == ITEM_MINUTE) begin
                  minute_d = (minute_q >= MINSEC_MAX) ? 6'd0 : minute_q + 6'd1;
                end else if (item_q == ITEM_THRESH) begin
                  thr_d = (thr_q >= THR_MAX) ? THR_MIN : thr_q + 6'd1;
                end
              end else if (in_key_q == KEY_3) begin
                // Step the chosen item down with wrap
                if (item_q == ITEM_HOUR) begin
                  hour_d = (hour_q == 5'd0) ? HOUR_MAX : hour_q - 5'd1;
                end else if (item_q == ITEM_MINUTE) begin
                  minute_d = (minute_q == 6'd0) ? MINSEC_MAX : minute_q - 6'd1;
                end else if (item_q == ITEM_THRESH) begin
                  thr_d = (thr_q <= THR_MIN) ? THR_MAX : thr_q - 6'd1;
                end
              end
            end
            default: begin
              // Unused mode code: hold
            end
          endcase
        end
      end
      ACT_TEMP: begin
        temp_d = in_temp_q;
      end
      ACT_EMERG: begin
        mode_d = MODE_SET;
        item_d = ITEM_THRESH;
        chirps = CHIRP_EMERG;
      end
      default: begin
      end
    endcase

    // Refresh the LED pattern only while the temperature view is up
    if (mode_d == MODE_TEMP) begin
      priority if (temp_d > T_HOT) begin
        pattern_d = PAT_HOT;
      end else if (temp_d < T_COLD) begin
        pattern_d = PAT_COLD;
      end else begin
        pattern_d = PAT_MODERATE;
      end
    end

    priority if (temp_d > T_DUTY_HI) begin
      duty = DUTY_HI;
    end else if (temp_d > T_DUTY_MID) begin
      duty = DUTY_MID;
    end else begin
      duty = DUTY_LO;
    end

    out_data_d = {1'b0, pattern_d, duty, chirps, alarm_d, thr_d, item_d, mode_d,
                  second_d, minute_d, hour_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      hour_q     <= HOUR_RST;
      minute_q   <= '0;
      second_q   <= '0;
      mode_q     <= MODE_TEMP;
      item_q     <= ITEM_HOUR;
      thr_q      <= THR_RST;
      temp_q     <= TEMP_RST;
      alarm_q    <= 1'b0;
      last_key_q <= KEY_NONE;
      pattern_q  <= PAT_COLD;
    end else if (advance) begin
      tick_q     <= tick_d;
      hour_q     <= hour_d;
      minute_q   <= minute_d;
      second_q   <= second_d;
      mode_q     <= mode_d;
      item_q     <= item_d;
      thr_q      <= thr_d;
      temp_q     <= temp_d;
      alarm_q    <= alarm_d;
      last_key_q <= last_key_d;
      pattern_q  <= pattern_d;
    end
  end

  // Result valid: set on a new result, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  // Clock and threshold stay within range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hour_q <= HOUR_MAX) && (minute_q <= MINSEC_MAX) && (second_q <= MINSEC_MAX))
    else $error("clock register out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (thr_q >= THR_MIN) && (thr_q <= THR_MAX))
    else $error("threshold out of range");

  // An emergency result always shows the threshold setting view
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[29:28] == CHIRP_EMERG) |->
      (m_axis_tdata[18:17] == MODE_SET && m_axis_tdata[20:19] == ITEM_THRESH))
    else $error("emergency result without setting view");

  // Input stalls only with an event held behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without cause");

endmodule
